@@ rtl/core/mcmp_pkg.sv @@
// Package for the MIDI channel message parser.
// Message kind codes, status decode and the result record; no dependencies.
`default_nettype none

package mcmp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned BendW   = 16;
  localparam int unsigned BendSh  = 7;

  localparam logic [ByteW-1:0] StatusBit  = 8'h80;
  localparam logic [ByteW-1:0] HighNibble = 8'hF0;
  localparam logic [ByteW-1:0] LowNibble  = 8'h0F;

  // Status nibbles of the channel voice messages handled here
  localparam logic [3:0] NibNoteOff  = 4'h8;
  localparam logic [3:0] NibNoteOn   = 4'h9;
  localparam logic [3:0] NibCtrlChg  = 4'hB;
  localparam logic [3:0] NibProgChg  = 4'hC;
  localparam logic [3:0] NibChanPres = 4'hD;
  localparam logic [3:0] NibPitchBnd = 4'hE;

  typedef enum logic [KindW-1:0] {
    KIND_NOTE_OFF  = 3'd0,
    KIND_NOTE_ON   = 3'd1,
    KIND_CTRL_CHG  = 3'd2,
    KIND_PROG_CHG  = 3'd3,
    KIND_CHAN_PRES = 3'd4,
    KIND_PITCH_BND = 3'd5,
    KIND_NONE      = 3'd7
  } kind_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ChanW-1:0] channel;
    logic [ByteW-1:0] first;
    logic [ByteW-1:0] second;
    logic [BendW-1:0] bend;
  } msg_t;

  function automatic kind_e kind_of(input logic [ByteW-1:0] status);
    logic [3:0] nib;
    kind_e      k;
    nib = 4'((status & HighNibble) >> 4);
    case (nib)
      NibNoteOff:  k = KIND_NOTE_OFF;
      NibNoteOn:   k = KIND_NOTE_ON;
      NibCtrlChg:  k = KIND_CTRL_CHG;
      NibProgChg:  k = KIND_PROG_CHG;
      NibChanPres: k = KIND_CHAN_PRES;
      NibPitchBnd: k = KIND_PITCH_BND;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Program change and channel pressure carry one data byte, the rest two
  function automatic logic needs_two(input kind_e k);
    return !(k == KIND_PROG_CHG || k == KIND_CHAN_PRES);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mcmp_decoder.sv @@
// Parser state and message assembly, one byte per transfer.
// Depends on mcmp_pkg.
`default_nettype none

module mcmp_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        byte_valid_i,
  input  wire logic [mcmp_pkg::ByteW-1:0]  byte_i,
  output logic                             res_valid_o,
  output mcmp_pkg::msg_t                   res_o
);

  logic                       in_msg_q, in_msg_d;
  logic [mcmp_pkg::ByteW-1:0] status_q, status_d;
  logic [mcmp_pkg::ByteW-1:0] first_q, first_d;
  logic [1:0]                 held_q, held_d;

  mcmp_pkg::kind_e            kind;
  logic [mcmp_pkg::ByteW-1:0] first, second;
  logic [mcmp_pkg::BendW-1:0] bend;

  assign kind = mcmp_pkg::kind_of(status_q);
  assign bend = mcmp_pkg::BendW'(first) | (mcmp_pkg::BendW'(second) << mcmp_pkg::BendSh);

  always_comb begin
    in_msg_d    = in_msg_q;
    status_d    = status_q;
    first_d     = first_q;
    held_d      = held_q;
    res_valid_o = 1'b0;
    first       = first_q;
    second      = byte_i;
    if (byte_valid_i) begin
      if (!in_msg_q) begin
        if ((byte_i & mcmp_pkg::StatusBit) != '0) begin
          status_d = byte_i;
          if (mcmp_pkg::kind_of(byte_i) == mcmp_pkg::KIND_NONE) begin
            held_d = 2'd0;
          end else begin
            in_msg_d = 1'b1;
            held_d   = 2'd1;
          end
        end
      end else if (kind == mcmp_pkg::KIND_NONE || held_q == 2'd0 || held_q == 2'd3) begin
        // unreachable state: drop back to idle
        in_msg_d = 1'b0;
        held_d   = 2'd0;
      end else if (held_q == 2'd1) begin
        first_d = byte_i;
        if (mcmp_pkg::needs_two(kind)) begin
          held_d = 2'd2;
        end else begin
          first       = byte_i;
          second      = '0;
          res_valid_o = 1'b1;
          in_msg_d    = 1'b0;
          held_d      = 2'd0;
        end
      end else begin
        in_msg_d    = 1'b0;
        held_d      = 2'd0;
        res_valid_o = mcmp_pkg::needs_two(kind);
      end
    end
  end

  always_comb begin
    res_o.kind    = kind;
    res_o.channel = mcmp_pkg::ChanW'(status_q & mcmp_pkg::LowNibble);
    res_o.first   = first;
    res_o.second  = second;
    res_o.bend    = (kind == mcmp_pkg::KIND_PITCH_BND) ? bend : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      status_q <= '0;
      first_q  <= '0;
      held_q   <= 2'd0;
    end else begin
      in_msg_q <= in_msg_d;
      status_q <= status_d;
      first_q  <= first_d;
      held_q   <= held_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mcmp_out_buf.sv @@
// Result register with a skid entry so the input side keeps moving
// while a result waits. Depends on mcmp_pkg.
`default_nettype none

module mcmp_out_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           res_valid_i,
  input  wire mcmp_pkg::msg_t res_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output mcmp_pkg::msg_t      out_o
);

  logic           out_vld_q, skid_vld_q;
  mcmp_pkg::msg_t out_q, skid_q;
  logic           out_free;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q || res_valid_i;
      skid_vld_q <= 1'b0;
    end else if (res_valid_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : res_i;
    end else if (res_valid_i) begin
      skid_q <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/midi_channel_message_parser.sv @@
// Top level of the MIDI channel voice message parser (no running status).
// Depends on mcmp_pkg, mcmp_decoder and mcmp_out_buf.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | sink      | in_valid_i / in_stall_o | midi_byte_i
//   out     | source    | out_valid_o/ out_stall_i| message_kind_o, midi_channel_o,
//           |           |                        | first_data_o, second_data_o,
//           |           |                        | bend_amount_o
//
// One byte is taken per cycle while the input is not stalled. A completing
// byte's result is registered in the output register, or the skid entry.
// Reset (async, active low) returns the parser to idle and empties the output.
// A stalled result sits in the output register; one more result fits in the
// skid entry, and only while that entry is occupied is the input stalled.
`default_nettype none

module midi_channel_message_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  midi_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       message_kind_o,
  output logic [3:0]       midi_channel_o,
  output logic [7:0]       first_data_o,
  output logic [7:0]       second_data_o,
  output logic [15:0]      bend_amount_o
);

  logic           in_xfer;
  logic           res_valid;
  mcmp_pkg::msg_t res, out_msg;

  // a byte transfers when offered and the skid entry is free
  assign in_xfer = in_valid_i && !in_stall_o;

  mcmp_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_xfer),
    .byte_i       (midi_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  mcmp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_msg)
  );

  assign message_kind_o = out_msg.kind;
  assign midi_channel_o = out_msg.channel;
  assign first_data_o   = out_msg.first;
  assign second_data_o  = out_msg.second;
  assign bend_amount_o  = out_msg.bend;

endmodule

`default_nettype wire

@@ rtl/core/mcmp_checker.sv @@
// Port-level checks for the MIDI channel message parser, bound to the top.
// Depends on mcmp_pkg.
`default_nettype none

module mcmp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [7:0]  midi_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  message_kind_o,
  input wire logic [3:0]  midi_channel_o,
  input wire logic [7:0]  first_data_o,
  input wire logic [7:0]  second_data_o,
  input wire logic [15:0] bend_amount_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(message_kind_o) && $stable(midi_channel_o)
      && $stable(first_data_o) && $stable(second_data_o) && $stable(bend_amount_o))
    else $error("result changed while stalled");

  a_kind_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> message_kind_o <= 3'(mcmp_pkg::KIND_PITCH_BND))
    else $error("bad message kind");

  a_bend_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_kind_o != 3'(mcmp_pkg::KIND_PITCH_BND) |-> bend_amount_o == '0)
    else $error("bend amount on a non-bend message");

  a_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (message_kind_o == 3'(mcmp_pkg::KIND_PROG_CHG)
      || message_kind_o == 3'(mcmp_pkg::KIND_CHAN_PRES)) |-> second_data_o == '0)
    else $error("second data on a one-byte message");

  // input side is observed but carries no check of its own here
  logic unused_in;
  assign unused_in = ^{in_valid_i, in_stall_o, midi_byte_i};

endmodule

bind midi_channel_message_parser mcmp_checker u_mcmp_checker (.*);

`default_nettype wire

@@ bench/mcmp_checker.sv @@
// Checker for the MIDI channel message parser: watches both channels,
// predicts each decoded message from the accepted bytes and compares.
// Depends on mcmp_pkg for the kind codes, status nibbles and msg_t.
module mcmp_scoreboard (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [7:0]  midi_byte_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [2:0]  message_kind_i,
  input  wire logic [3:0]  midi_channel_i,
  input  wire logic [7:0]  first_data_i,
  input  wire logic [7:0]  second_data_i,
  input  wire logic [15:0] bend_amount_i,
  output int               fail_count_o,
  output int               pending_o
);

  // Parser state as predicted
  logic       in_msg;
  logic [7:0] cur_status;
  logic [7:0] cur_first;
  logic [1:0] cur_count;

  mcmp_pkg::msg_t expected_msgs[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic mcmp_pkg::kind_e status_kind(input logic [7:0] status);
    case (status[7:4])
      mcmp_pkg::NibNoteOff:  return mcmp_pkg::KIND_NOTE_OFF;
      mcmp_pkg::NibNoteOn:   return mcmp_pkg::KIND_NOTE_ON;
      mcmp_pkg::NibCtrlChg:  return mcmp_pkg::KIND_CTRL_CHG;
      mcmp_pkg::NibProgChg:  return mcmp_pkg::KIND_PROG_CHG;
      mcmp_pkg::NibChanPres: return mcmp_pkg::KIND_CHAN_PRES;
      mcmp_pkg::NibPitchBnd: return mcmp_pkg::KIND_PITCH_BND;
      default:               return mcmp_pkg::KIND_NONE;
    endcase
  endfunction

  task automatic emit_msg(input mcmp_pkg::kind_e k, input logic [7:0] d1,
                          input logic [7:0] d2);
    mcmp_pkg::msg_t m;
    m.kind    = k;
    m.channel = cur_status[3:0];
    m.first   = d1;
    m.second  = d2;
    m.bend    = (k == mcmp_pkg::KIND_PITCH_BND)
                ? (16'(d1) | (16'(d2) << mcmp_pkg::BendSh)) : '0;
    expected_msgs.insert(expected_msgs.size(), m);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    mcmp_pkg::kind_e k;
    logic            two;
    if (!in_msg) begin
      if (!b[7]) return;
      cur_status = b;
      cur_count  = 2'd1;
      in_msg     = (status_kind(b) != mcmp_pkg::KIND_NONE);
      if (!in_msg) cur_count = 2'd0;
      return;
    end
    k   = status_kind(cur_status);
    two = !(k == mcmp_pkg::KIND_PROG_CHG || k == mcmp_pkg::KIND_CHAN_PRES);
    if (k == mcmp_pkg::KIND_NONE || cur_count == 2'd0 || cur_count > 2'd2) begin
      in_msg    = 1'b0;
      cur_count = 2'd0;
      return;
    end
    if (cur_count == 2'd1) begin
      cur_first = b;
      if (two) begin
        cur_count = 2'd2;
        return;
      end
      emit_msg(k, b, 8'h00);
    end else if (two) begin
      emit_msg(k, cur_first, b);
    end
    in_msg    = 1'b0;
    cur_count = 2'd0;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mcmp_pkg::msg_t m;
    if (!rst_ni) begin
      in_msg     = 1'b0;
      cur_status = '0;
      cur_first  = '0;
      cur_count  = '0;
      expected_msgs.delete();
    end else begin
      // results out first: a byte taken at this edge cannot have produced one yet
      if (out_valid_i && !out_stall_i) begin
        if (expected_msgs.size() == 0) begin
          $display("%0t: unexpected message, expected none, actual kind %0h ch %0h",
                   $time, message_kind_i, midi_channel_i);
          fail_count_o++;
        end else begin
          m = expected_msgs.pop_front();
          check_field("message_kind", m.kind,    message_kind_i);
          check_field("midi_channel", m.channel, midi_channel_i);
          check_field("first_data",   m.first,   first_data_i);
          check_field("second_data",  m.second,  second_data_i);
          check_field("bend_amount",  m.bend,    bend_amount_i);
        end
      end
      if (in_valid_i && !in_stall_i) parse_byte(midi_byte_i);
    end
    pending_o = expected_msgs.size();
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the MIDI channel message parser: drives byte streams
// with random gaps and output stalls, and reports the verdict.
// Depends on mcmp_pkg, midi_channel_message_parser and mcmp_scoreboard.
module tb;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  midi_byte_i = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  message_kind_o;
  logic [3:0]  midi_channel_o;
  logic [7:0]  first_data_o;
  logic [7:0]  second_data_o;
  logic [15:0] bend_amount_o;

  int fail_count;
  int pending;

  // Random gaps and stalls are on only while this is set
  logic idling_on = 1'b0;
  int   stall_left = 0;
  int   bytes_sent = 0;

  // Directed bytes: dropped data while idle, every kind with channel and
  // data extremes, status-like data bytes, unsupported statuses, and a
  // status byte absorbed as data inside a message.
  logic [7:0] directed_bytes [0:27] = '{
    8'h00, 8'h7F,
    8'h80, 8'h00, 8'h7F,
    8'h9F, 8'h7F, 8'h00,
    8'hB5, 8'h80, 8'hFF,
    8'hC3, 8'h00,
    8'hDA, 8'hFF,
    8'hE0, 8'h7F, 8'h7F,
    8'hEF, 8'hFF, 8'hFF,
    8'hA1, 8'h10,
    8'hF0, 8'hFF,
    8'h90, 8'h80, 8'h90
  };

  always #2 clk_i = ~clk_i;

  midi_channel_message_parser DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .midi_byte_i    (midi_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .message_kind_o (message_kind_o),
    .midi_channel_o (midi_channel_o),
    .first_data_o   (first_data_o),
    .second_data_o  (second_data_o),
    .bend_amount_o  (bend_amount_o)
  );

  mcmp_scoreboard u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .midi_byte_i    (midi_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .message_kind_i (message_kind_o),
    .midi_channel_i (midi_channel_o),
    .first_data_i   (first_data_o),
    .second_data_i  (second_data_o),
    .bend_amount_i  (bend_amount_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Output stall: random bursts while idling is on
  always @(posedge clk_i) begin
    if (!idling_on) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  = $urandom_range(1, 8) - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // One byte transfer; an optional gap goes in before valid rises, so valid
  // is never dropped and raised in the same step.
  task automatic send_byte(input logic [7:0] b);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    midi_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Mostly 7-bit data, sometimes a full byte so bit 7 reaches the data path
  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 127));
  endfunction

  // A status with random nibble and channel, followed by the data bytes its
  // kind needs; sometimes one byte short or long so messages straddle.
  task automatic send_message();
    logic [3:0] nib;
    int         n;
    nib = 4'($urandom_range(8, 15));
    case (nib)
      mcmp_pkg::NibProgChg, mcmp_pkg::NibChanPres: n = 1;
      mcmp_pkg::NibNoteOff, mcmp_pkg::NibNoteOn, mcmp_pkg::NibCtrlChg,
      mcmp_pkg::NibPitchBnd:                       n = 2;
      default:                                     n = $urandom_range(0, 2);
    endcase
    if ($urandom_range(0, 15) == 0) n = n + 1;
    else if (n > 0 && $urandom_range(0, 15) == 0) n = n - 1;
    send_byte({nib, 4'($urandom)});
    repeat (n) send_byte(rand_data());
  endtask

  // wait for a clock edge first so the count already holds the last byte's message
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no gaps
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // Hold off until every message so far has come out
    in_valid_i <= 1'b0;
    wait_drained();

    // Random part in segments, some without idling
    while (bytes_sent < 1400) begin
      idling_on = ($urandom_range(0, 3) != 0);
      repeat (40) begin
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
        else send_message();
      end
    end

    // Closing stretch at full rate
    idling_on = 1'b0;
    while (bytes_sent < 1500) send_message();
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("midi_channel_message_parser test passed");
    end else begin
      $display("midi_channel_message_parser test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("midi_channel_message_parser test failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mcmp_pkg.sv
rtl/core/mcmp_decoder.sv
rtl/core/mcmp_out_buf.sv
rtl/core/midi_channel_message_parser.sv
rtl/core/mcmp_checker.sv
bench/mcmp_checker.sv
bench/tb.sv
